[hw/rtl/hmte_pkg.sv]
package hmte_pkg;

  localparam int WIN_DEPTH = 8;
  localparam int FILL_W    = 4;
  localparam int CNT_W     = 17;

  localparam logic [CNT_W-1:0] CAP_RESET = 17'd120000;

  typedef logic [7:0] byte_t;
  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             in_tag;
    logic             in_script;
    logic [2:0]       skip;
    logic             prev_space;
    logic [CNT_W-1:0] count;
  } mode_t;

  typedef struct packed {
    byte_t ch;
    logic  cv;
    logic  pd;
  } result_t;

  typedef struct packed {
    logic shift;
    logic is_tail;
  } cell_ctl_t;

  localparam byte_t CH_LT   = 8'h3C;
  localparam byte_t CH_GT   = 8'h3E;
  localparam byte_t CH_AMP  = 8'h26;
  localparam byte_t CH_CR   = 8'h0D;
  localparam byte_t CH_LF   = 8'h0A;
  localparam byte_t CH_TAB  = 8'h09;
  localparam byte_t CH_SP   = 8'h20;
  localparam byte_t CH_UA   = 8'h41;
  localparam byte_t CH_UZ   = 8'h5A;
  localparam byte_t CASE_UP = 8'h20;

  localparam logic [47:0] W_SCRIPT  = "script";
  localparam logic [47:0] W_STYLE   = "style>";
  localparam logic [47:0] W_ESCRIPT = "/scrip";
  localparam logic [47:0] W_ESTYLE  = "/style";

  localparam logic [23:0] ENT_LT   = "lt;";
  localparam logic [23:0] ENT_GT   = "gt;";
  localparam logic [31:0] ENT_AMP  = "amp;";
  localparam logic [39:0] ENT_NBSP = "nbsp;";

  function automatic byte_t lower_byte(byte_t c);
    return (c >= CH_UA && c <= CH_UZ) ? c + CASE_UP : c;
  endfunction

  // bytes after the '<', lower-cased, against a six-letter word
  function automatic logic tag_is(win_t v, logic [47:0] w);
    logic hit;
    hit = 1'b1;
    for (int k = 0; k < 6; k++) begin
      if (lower_byte(v[1+k]) != w[47-8*k -: 8]) hit = 1'b0;
    end
    return hit;
  endfunction

endpackage

[hw/rtl/html_markup_text_extractor.sv]
// Visible-text extractor. Takes one markup byte per cycle while in_ready is
// high and emits the page's visible text, one character per output request.
// Bytes pass through an eight-cell shift window; a byte is decided as it
// leaves the head, so a character appears seven bytes after its own byte
// went in. On the byte with end_of_page set the block stops taking input,
// drains the window one byte per cycle while the output queue has room, then
// issues the closing request with page_done (char_valid low if the drain kept
// no character). A two-deep output queue decouples the sides; input is held
// off only while it is full, draining or closing. The user must write
// max_chars via cfg_wr_en/cfg_wr_data while the block is idle; not enforced.
module html_markup_text_extractor
  import hmte_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             end_of_page,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       text_char,
  output logic             char_valid,
  output logic             page_done,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  state_t            state;
  state_t            state_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  mode_t             mode;
  mode_t             mode_next;
  mode_t             dec_mode;
  logic [CNT_W-1:0]  max_chars;
  byte_t             held;
  byte_t             held_next;
  logic              held_v;
  logic              held_v_next;

  logic              space;
  logic              accept;
  logic              flush_step;
  logic              finish_step;
  logic              head_step;
  logic [FILL_W-1:0] dec_fill;
  logic              emit;
  byte_t             emit_ch;
  logic              push;
  result_t           push_res;
  result_t           out_res;

  win_t              view;
  byte_t             nbr [WIN_DEPTH];
  cell_ctl_t         cell_ctl [WIN_DEPTH];

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_DEPTH - 1);

  assign in_ready    = (state == ST_RUN) && space;
  assign accept      = in_valid && in_ready;
  assign flush_step  = (state == ST_FLUSH) && space;
  assign finish_step = (state == ST_FINISH) && space;
  assign head_step   = (accept && fill == FILL_LAST) || flush_step;
  assign dec_fill    = (state == ST_RUN) ? fill + FILL_W'(1) : fill;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == WIN_DEPTH - 1) begin : g_end
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = view[i+1];
    end
    assign cell_ctl[i].shift   = head_step;
    assign cell_ctl[i].is_tail = accept && (fill == FILL_W'(i));

    hmte_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .in_byte (in_byte),
      .nbr     (nbr[i]),
      .view    (view[i])
    );
  end

  hmte_decide u_decide (
    .view      (view),
    .fill      (dec_fill),
    .mode      (mode),
    .max_chars (max_chars),
    .mode_next (dec_mode),
    .emit      (emit),
    .emit_ch   (emit_ch)
  );

  hmte_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res  (push_res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign text_char  = out_res.ch;
  assign char_valid = out_res.cv;
  assign page_done  = out_res.pd;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN:    if (accept && end_of_page) state_next = ST_FLUSH;
      ST_FLUSH:  if (flush_step && fill == FILL_W'(1)) state_next = ST_FINISH;
      ST_FINISH: if (finish_step) state_next = ST_RUN;
      default:   state_next = ST_RUN;
    endcase
  end

  // during a page-end drain the newest character is held back until it is
  // known whether it is the last one
  always_comb begin
    push        = 1'b0;
    push_res    = '0;
    held_next   = held;
    held_v_next = held_v;
    fill_next   = fill;
    mode_next   = mode;
    if (head_step) mode_next = dec_mode;
    unique case (state)
      ST_RUN: begin
        if (accept) begin
          fill_next = (fill == FILL_LAST) ? FILL_LAST : fill + FILL_W'(1);
          if (head_step && emit) begin
            if (end_of_page) begin
              held_next   = emit_ch;
              held_v_next = 1'b1;
            end else begin
              push     = 1'b1;
              push_res = '{ch: emit_ch, cv: 1'b1, pd: 1'b0};
            end
          end
        end
      end
      ST_FLUSH: begin
        if (flush_step) begin
          fill_next = fill - FILL_W'(1);
          if (emit) begin
            if (held_v) begin
              push     = 1'b1;
              push_res = '{ch: held, cv: 1'b1, pd: 1'b0};
            end
            held_next   = emit_ch;
            held_v_next = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (finish_step) begin
          push        = 1'b1;
          push_res    = '{ch: held_v ? held : byte_t'(0), cv: held_v, pd: 1'b1};
          held_v_next = 1'b0;
          mode_next   = '0;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    held <= held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      fill      <= '0;
      mode      <= '0;
      held_v    <= 1'b0;
      max_chars <= CAP_RESET;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      mode   <= mode_next;
      held_v <= held_v_next;
      if (cfg_wr_en) max_chars <= cfg_wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == ST_RUN) |-> !held_v)
    else $error("held character left over outside a page-end drain");
  assert property (@(posedge clk) disable iff (rst) (state == ST_FINISH) |-> (fill == '0))
    else $error("closing request issued with bytes still in the window");
  assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_page) |=> (state == ST_FLUSH && fill != '0))
    else $error("page end did not start a drain");

endmodule

[hw/rtl/hmte_cell.sv]
module hmte_cell
  import hmte_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  byte_t     in_byte,
  input  byte_t     nbr,
  output byte_t     view
);

  byte_t stored;

  // the tail cell shows the incoming byte in the same cycle
  assign view = ctl.is_tail ? in_byte : stored;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      stored <= nbr;
    end else if (ctl.is_tail) begin
      stored <= in_byte;
    end
  end

endmodule

[hw/rtl/hmte_decide.sv]
module hmte_decide
  import hmte_pkg::*;
(
  input  win_t              view,
  input  logic [FILL_W-1:0] fill,
  input  mode_t             mode,
  input  logic [CNT_W-1:0]  max_chars,
  output mode_t             mode_next,
  output logic              emit,
  output byte_t             emit_ch
);

  always_comb begin
    byte_t c;
    byte_t ch;
    logic  take;
    c         = view[0];
    ch        = c;
    take      = 1'b0;
    mode_next = mode;
    emit      = 1'b0;
    emit_ch   = c;

    if (mode.skip != 3'd0) begin
      mode_next.skip = mode.skip - 3'd1;
    end else if (c == CH_LT) begin
      mode_next.in_tag = 1'b1;
      if (fill >= FILL_W'(WIN_DEPTH)) begin
        if (tag_is(view, W_SCRIPT) || tag_is(view, W_STYLE)) mode_next.in_script = 1'b1;
        if (tag_is(view, W_ESCRIPT) || tag_is(view, W_ESTYLE)) mode_next.in_script = 1'b0;
      end
    end else if (c == CH_GT) begin
      mode_next.in_tag = 1'b0;
    end else if (!(mode.in_tag || mode.in_script)) begin
      take = 1'b1;
      if (c == CH_AMP) begin
        if (fill >= FILL_W'(4) && {view[1], view[2], view[3]} == ENT_LT) begin
          ch = CH_LT;
          mode_next.skip = 3'd3;
        end else if (fill >= FILL_W'(4) && {view[1], view[2], view[3]} == ENT_GT) begin
          ch = CH_GT;
          mode_next.skip = 3'd3;
        end else if (fill >= FILL_W'(5)
                     && {view[1], view[2], view[3], view[4]} == ENT_AMP) begin
          ch = CH_AMP;
          mode_next.skip = 3'd4;
        end else if (fill >= FILL_W'(6)
                     && {view[1], view[2], view[3], view[4], view[5]} == ENT_NBSP) begin
          ch = CH_SP;
          mode_next.skip = 3'd5;
        end
      end
    end

    // whitespace folding and the per-page cap
    if (take && ch != CH_CR) begin
      if (ch == CH_LF || ch == CH_TAB) ch = CH_SP;
      if (!(ch == CH_SP && mode.prev_space)) begin
        mode_next.prev_space = (ch == CH_SP);
        if (mode.count < max_chars) begin
          mode_next.count = mode.count + CNT_W'(1);
          emit            = 1'b1;
          emit_ch         = ch;
        end
      end
    end
  end

endmodule

[hw/rtl/hmte_outq.sv]
module hmte_outq
  import hmte_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_res   = slot[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> space)
    else $error("request pushed into a full output queue");
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output queue count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("output queue count did not drop on pop");

endmodule
